/* src/ivalloc_pkg.sv */
package ivalloc_pkg;

    localparam int NUM_VECTORS = 256;
    localparam int VW = $clog2(NUM_VECTORS);

    localparam logic [2:0] OP_RESERVE    = 3'd0;
    localparam logic [2:0] OP_UNRESERVE  = 3'd1;
    localparam logic [2:0] OP_CONNECT    = 3'd2;
    localparam logic [2:0] OP_DISCONNECT = 3'd3;
    localparam logic [2:0] OP_SHARE      = 3'd4;

    localparam int FLAG_RESV  = 0;
    localparam int FLAG_CONN  = 1;
    localparam int FLAG_SHARE = 2;

    localparam logic CFG_FIRST = 1'b0;
    localparam logic CFG_LAST  = 1'b1;

    localparam logic [7:0] CNT_MAX   = 8'd255;
    localparam logic [8:0] INUSE_MAX = 9'd511;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  vector_number;
        logic        any_vector;
        logic [15:0] vendor_id;
        logic [15:0] device_id;
    } t_in;

    typedef struct packed {
        logic       success;
        logic [7:0] vector_result;
        logic       was_shared;
    } t_out;

    typedef struct packed {
        logic [2:0]  flags;
        logic [7:0]  cnt;
        logic [31:0] cls;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic          clr;
        logic          en;
        logic [VW-1:0] idx;
        logic [7:0]    last;
        logic [31:0]   cls;
    } t_scan_ctl;

    typedef struct packed {
        logic          free_fnd;
        logic [VW-1:0] free_idx;
        logic          cls_fnd;
        logic [VW-1:0] cls_idx;
        logic          all_fnd;
        logic [VW-1:0] all_idx;
    } t_scan_res;

endpackage

/* src/interrupt_vector_allocator.sv */
// channel  direction  handshake                   payload
// in       input      i_in_valid / o_in_ready     i_in  (opcode, vector, class)
// out      output     o_out_valid / i_out_ready   o_out (success, vector, shared)
// cfg      input      i_cfg_we                    i_cfg_idx, i_cfg_wdata
//
// one item at a time; a reserve with any_vector walks the device window once
// through the table ram (one entry a cycle); if a vector qualifies it is read
// and written like a named operation, which reads its entry and writes it
// back; undefined opcodes and an empty window report without a table access
// the result is held until taken; no new item is accepted meanwhile
// reset clears per-entry valid bits at once, so no clearing pass is needed
module interrupt_vector_allocator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ivalloc_pkg::t_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ivalloc_pkg::t_out o_out,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [7:0]        i_cfg_wdata
);
    localparam int VW = ivalloc_pkg::VW;
    localparam int NV = ivalloc_pkg::NUM_VECTORS;
    localparam logic [8:0] NV9 = 9'(NV);
    localparam logic [8:0] TOP9 = 9'(NV - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_PICK = 6'b000100,
        S_RD   = 6'b001000,
        S_WR   = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [7:0] r_first, r_last;
    ivalloc_pkg::t_in  r_in;
    ivalloc_pkg::t_out r_out, n_out;
    logic [VW-1:0] r_addr, n_addr;
    logic [VW-1:0] r_didx, n_didx;
    logic r_dv, n_dv, r_idone, n_idone;
    logic r_shared, n_shared;
    logic [7:0] r_vec, n_vec;
    logic [8:0] r_inuse, n_inuse;
    logic [NV-1:0] r_valid;
    logic r_rvld;

    logic [VW-1:0] rd_addr;
    logic [ivalloc_pkg::ENTRY_W-1:0] ram_rdata;
    ivalloc_pkg::t_entry ent, wr_ent;
    logic wr_en;
    logic [8:0] scan_end;
    logic [31:0] req_cls;
    ivalloc_pkg::t_scan_ctl sctl;
    ivalloc_pkg::t_scan_res sres;
    logic accept;

    assign accept      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out       = r_out;
    assign req_cls     = {r_in.vendor_id, r_in.device_id};
    assign ent         = r_rvld ? ivalloc_pkg::t_entry'(ram_rdata) : '0;
    assign scan_end    = ({1'b0, r_last} > TOP9) ? TOP9 : {1'b0, r_last};

    ivalloc_ram #(.WIDTH(ivalloc_pkg::ENTRY_W), .DEPTH(NV)) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_vec[VW-1:0]),
        .i_wdata (wr_ent),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    ivalloc_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sctl),
        .i_ent   (ent),
        .o_res   (sres)
    );

    always_comb begin
        n_state  = r_state;
        n_out    = r_out;
        n_addr   = r_addr;
        n_didx   = r_didx;
        n_dv     = 1'b0;
        n_idone  = r_idone;
        n_shared = r_shared;
        n_vec    = r_vec;
        n_inuse  = r_inuse;
        rd_addr  = r_addr;
        wr_en    = 1'b0;
        wr_ent   = ent;
        sctl.clr  = 1'b0;
        sctl.en   = 1'b0;
        sctl.idx  = r_didx;
        sctl.last = r_last;
        sctl.cls  = req_cls;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_vec    = i_in.vector_number;
                    n_shared = 1'b0;
                    n_out    = '{success: 1'b0, vector_result: i_in.vector_number,
                                 was_shared: 1'b0};
                    if (i_in.opcode > ivalloc_pkg::OP_SHARE) begin
                        n_state = S_OUT;
                    end else if (i_in.opcode == ivalloc_pkg::OP_RESERVE && i_in.any_vector) begin
                        if (r_first > r_last || {1'b0, r_first} >= NV9) begin
                            n_out.vector_result = 8'd0;
                            n_state = S_OUT;
                        end else begin
                            sctl.clr = 1'b1;
                            n_addr   = r_first[VW-1:0];
                            n_idone  = 1'b0;
                            n_state  = S_SCAN;
                        end
                    end else if ({1'b0, i_in.vector_number} >= NV9) begin
                        n_state = S_OUT;
                    end else begin
                        n_addr  = i_in.vector_number[VW-1:0];
                        n_state = S_RD;
                    end
                end
            end
            S_SCAN: begin
                sctl.en = r_dv;
                if (!r_idone) begin
                    n_dv   = 1'b1;
                    n_didx = r_addr;
                    if ({1'b0, 8'(r_addr)} == scan_end) begin
                        n_idone = 1'b1;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end else if (!r_dv) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (sres.free_fnd) begin
                    n_vec = 8'(sres.free_idx);
                end else if (sres.cls_fnd) begin
                    n_vec    = 8'(sres.cls_idx);
                    n_shared = 1'b1;
                end else if (sres.all_fnd) begin
                    n_vec    = 8'(sres.all_idx);
                    n_shared = 1'b1;
                end
                // no candidate at all reports vector 0
                n_out.vector_result = (sres.free_fnd || sres.cls_fnd || sres.all_fnd) ?
                                      n_vec : 8'd0;
                n_addr  = n_vec[VW-1:0];
                n_state = (sres.free_fnd || sres.cls_fnd || sres.all_fnd) ? S_RD : S_OUT;
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                wr_en   = 1'b1;
                n_state = S_OUT;
                n_out.vector_result = r_vec;
                case (r_in.opcode)
                    ivalloc_pkg::OP_RESERVE: begin
                        if (r_shared && ent.cnt != ivalloc_pkg::CNT_MAX) begin
                            wr_ent.cnt = ent.cnt + 8'd1;
                        end
                        if (!ent.flags[ivalloc_pkg::FLAG_SHARE] &&
                            ent.flags[ivalloc_pkg::FLAG_RESV]) begin
                            n_out.success = 1'b0;
                        end else begin
                            if (!ent.flags[ivalloc_pkg::FLAG_SHARE] &&
                                r_inuse != ivalloc_pkg::INUSE_MAX) begin
                                n_inuse = r_inuse + 9'd1;
                            end
                            wr_ent.flags[ivalloc_pkg::FLAG_RESV] = 1'b1;
                            wr_ent.cls        = req_cls;
                            n_out.success     = 1'b1;
                            n_out.was_shared  = r_shared;
                        end
                    end
                    ivalloc_pkg::OP_UNRESERVE: begin
                        if (ent.flags[ivalloc_pkg::FLAG_RESV]) begin
                            if (r_inuse != 9'd0) begin
                                n_inuse = r_inuse - 9'd1;
                            end
                            wr_ent.flags[ivalloc_pkg::FLAG_RESV] = 1'b0;
                            n_out.success = 1'b1;
                        end
                    end
                    ivalloc_pkg::OP_CONNECT: begin
                        if (ent.flags[ivalloc_pkg::FLAG_SHARE] ||
                            !ent.flags[ivalloc_pkg::FLAG_CONN]) begin
                            wr_ent.flags[ivalloc_pkg::FLAG_CONN] = 1'b1;
                            n_out.success = 1'b1;
                        end
                    end
                    ivalloc_pkg::OP_DISCONNECT: begin
                        if (ent.flags[ivalloc_pkg::FLAG_CONN]) begin
                            wr_ent.flags[ivalloc_pkg::FLAG_CONN] = 1'b0;
                            n_out.success = 1'b1;
                        end
                    end
                    default: begin
                        wr_ent.flags[ivalloc_pkg::FLAG_SHARE] = 1'b1;
                        n_out.success = 1'b1;
                    end
                endcase
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 8'd0;
            r_last  <= 8'd255;
            r_inuse <= 9'd0;
            r_valid <= '0;
            r_dv    <= 1'b0;
            r_idone <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inuse <= n_inuse;
            r_dv    <= n_dv;
            r_idone <= n_idone;
            if (wr_en) begin
                r_valid[r_vec[VW-1:0]] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ivalloc_pkg::CFG_FIRST: r_first <= i_cfg_wdata;
                    ivalloc_pkg::CFG_LAST:  r_last  <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in;
        end
        r_out    <= n_out;
        r_addr   <= n_addr;
        r_didx   <= n_didx;
        r_shared <= n_shared;
        r_vec    <= n_vec;
        r_rvld   <= r_valid[rd_addr];
    end

`ifndef SYNTHESIS
    a_shared_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.was_shared |-> o_out.success)
        else $error("was_shared without success");
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("ready while result pending");
    a_wr_before_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> o_out_valid)
        else $error("table write not followed by result");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");
`endif
endmodule

/* src/ivalloc_ram.sv */
module ivalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/ivalloc_scan.sv */
module ivalloc_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ivalloc_pkg::t_scan_ctl i_ctl,
    input  ivalloc_pkg::t_entry   i_ent,
    output ivalloc_pkg::t_scan_res o_res
);
    ivalloc_pkg::t_scan_res r_res, n_res;
    logic [8:0] r_cls_cnt, n_cls_cnt;
    logic [8:0] r_all_cnt, n_all_cnt;
    logic       below_last;

    always_comb begin
        n_res      = r_res;
        n_cls_cnt  = r_cls_cnt;
        n_all_cnt  = r_all_cnt;
        below_last = {1'b0, i_ctl.idx} < {1'b0, i_ctl.last};
        if (i_ctl.clr) begin
            n_res     = '0;
            n_cls_cnt = 9'd256;
            n_all_cnt = 9'd256;
        end else if (i_ctl.en) begin
            if (!r_res.free_fnd && i_ent.flags == 3'd0) begin
                n_res.free_fnd = 1'b1;
                n_res.free_idx = i_ctl.idx;
            end
            // sharing candidates exclude the last window vector
            if (below_last) begin
                if (i_ent.cls == i_ctl.cls && {1'b0, i_ent.cnt} < r_cls_cnt) begin
                    n_res.cls_fnd = 1'b1;
                    n_res.cls_idx = i_ctl.idx;
                    n_cls_cnt     = {1'b0, i_ent.cnt};
                end
                if ({1'b0, i_ent.cnt} < r_all_cnt) begin
                    n_res.all_fnd = 1'b1;
                    n_res.all_idx = i_ctl.idx;
                    n_all_cnt     = {1'b0, i_ent.cnt};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res     <= '0;
            r_cls_cnt <= 9'd256;
            r_all_cnt <= 9'd256;
        end else begin
            r_res     <= n_res;
            r_cls_cnt <= n_cls_cnt;
            r_all_cnt <= n_all_cnt;
        end
    end

    assign o_res = r_res;
endmodule
